// ===== hw/rtl/rna_pkg.sv =====
// Shared types and constants of the rational-number ALU.
// Holds the transfer payload structs, command codes, sequencer states and status groups.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rna_pkg;

    localparam int unsigned FIELD_WIDTH       = 16;
    localparam int unsigned RES_WIDTH         = 32;
    localparam int unsigned OP_LIMIT          = 32;
    localparam int unsigned OPERAND_WIDTH_DEF = 16;
    localparam int unsigned DATA_WIDTH_DEF    = 2 * OPERAND_WIDTH_DEF + 2;

    typedef enum logic [2:0] {
        CMD_REDUCE   = 3'd0,
        CMD_NEGATE   = 3'd1,
        CMD_RECIP    = 3'd2,
        CMD_MULTIPLY = 3'd3,
        CMD_ADD_INT  = 3'd4,
        CMD_FROM_INT = 3'd5,
        CMD_EQUAL    = 3'd6,
        CMD_LESS     = 3'd7
    } rna_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEGATE,
        ST_NORM,
        ST_MLOAD,
        ST_MUL,
        ST_ADDN,
        ST_CMP,
        ST_RD_CHECK,
        ST_RD_ABSN,
        ST_RD_ABSD,
        ST_RD_TWOS,
        ST_RD_GCD,
        ST_RD_DIV,
        ST_RD_SIGN,
        ST_RD_END,
        ST_FIN
    } rna_state_t;

    typedef struct packed {
        logic [2:0]                    command;
        logic signed [FIELD_WIDTH-1:0] a_num;
        logic signed [FIELD_WIDTH-1:0] a_den;
        logic signed [FIELD_WIDTH-1:0] b_num;
        logic signed [FIELD_WIDTH-1:0] b_den;
        logic signed [FIELD_WIDTH-1:0] whole_value;
    } rna_in_t;

    typedef struct packed {
        logic signed [RES_WIDTH-1:0] res_num;
        logic signed [RES_WIDTH-1:0] res_den;
        logic                        compare_true;
        logic                        error;
    } rna_out_t;

    typedef struct packed {
        logic ready;
        logic done;
    } rna_eng_stat_t;

    typedef struct packed {
        logic carry;
        logic zero;
    } rna_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rna_addsub.sv =====
// Shared adder/subtractor of the rational-number ALU sequencer.
// Purely combinational; returns the sum plus carry and zero flags.
// Depends on rna_pkg for the flag struct.
`default_nettype none

module rna_addsub #(
    parameter int unsigned WIDTH = rna_pkg::DATA_WIDTH_DEF
) (
    input  logic [WIDTH-1:0]  op_a,
    input  logic [WIDTH-1:0]  op_b,
    input  logic              sub,
    output logic [WIDTH-1:0]  sum,
    output rna_pkg::rna_flags_t flags
);
    import rna_pkg::*;

    logic [WIDTH:0] full;

    // On a subtraction the carry out is high when op_a >= op_b, unsigned.
    assign full = {1'b0, op_a} + {1'b0, op_b ^ {WIDTH{sub}}} + {{WIDTH{1'b0}}, sub};
    assign sum         = full[WIDTH-1:0];
    assign flags.carry = full[WIDTH];
    assign flags.zero  = (full[WIDTH-1:0] == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/rna_engine.sv =====
// Sequencer and working registers of the rational-number ALU.
// Runs shift-add multiply, binary GCD and restoring division on one shared adder.
// Depends on rna_pkg and rna_addsub.
`default_nettype none

module rna_engine #(
    parameter int unsigned OPERAND_WIDTH = rna_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   take,
    input  rna_pkg::rna_in_t       op_in,
    output rna_pkg::rna_out_t      result,
    output rna_pkg::rna_eng_stat_t stat
);
    import rna_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned PW = 2 * W + 2;
    localparam int unsigned CW = $clog2(PW);

    rna_state_t state_reg, state_next;
    rna_cmd_t   cmd_reg, cmd_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic dsel_reg, dsel_next;
    logic sn_reg, sn_next;
    logic sd_reg, sd_next;
    logic err_reg, err_next;
    logic cmp_reg, cmp_next;

    logic signed [PW-1:0] an_reg, an_next;
    logic signed [PW-1:0] ad_reg, ad_next;
    logic signed [PW-1:0] bn_reg, bn_next;
    logic signed [PW-1:0] bd_reg, bd_next;
    logic signed [PW-1:0] wv_reg, wv_next;
    logic signed [PW-1:0] n_reg, n_next;
    logic signed [PW-1:0] d_reg, d_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mc_reg, mc_next;
    logic signed [PW-1:0] mp_reg, mp_next;
    logic signed [PW-1:0] u_reg, u_next;
    logic signed [PW-1:0] v_reg, v_next;

    logic [PW-1:0] u_a, u_b, u_sum;
    logic          u_sub;
    rna_flags_t    u_flags;

    logic signed [PW-1:0] ea_n, ea_d, eb_n, eb_d, e_w;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] div_q;
    logic [PW-1:0]        div_rs;
    logic                 neg_cond;
    logic                 a_bad, b_bad;

    // Keep the low OPERAND_WIDTH bits of a field, taken as two's complement.
    // Bits above the field itself read as zero.
    function automatic logic signed [PW-1:0] ext_op(input logic signed [FIELD_WIDTH-1:0] f);
        logic signed [OP_LIMIT-1:0] f32;
        logic signed [W-1:0]        fw;
        f32 = {{(OP_LIMIT - FIELD_WIDTH){1'b0}}, f};
        fw  = f32[W-1:0];
        return PW'(fw);
    endfunction

    assign ea_n = ext_op(op_in.a_num);
    assign ea_d = ext_op(op_in.a_den);
    assign eb_n = ext_op(op_in.b_num);
    assign eb_d = ext_op(op_in.b_den);
    assign e_w  = ext_op(op_in.whole_value);
    assign a_bad = (ea_d == '0);
    assign b_bad = (eb_d == '0);

    rna_addsub #(.WIDTH(PW)) u_addsub (
        .op_a  (u_a),
        .op_b  (u_b),
        .sub   (u_sub),
        .sum   (u_sum),
        .flags (u_flags)
    );

    assign prod     = mp_reg[0] ? u_sum : acc_reg;
    assign div_q    = dsel_reg ? d_reg : n_reg;
    assign div_rs   = {u_reg[PW-2:0], div_q[PW-1]};
    assign neg_cond = phase_reg[1] ? bd_reg[PW-1] : ad_reg[PW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            cnt_reg   <= '0;
            dsel_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            dsel_reg  <= dsel_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        sn_reg  <= sn_next;
        sd_reg  <= sd_next;
        err_reg <= err_next;
        cmp_reg <= cmp_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        wv_reg  <= wv_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        dsel_next  = dsel_reg;
        sn_next    = sn_reg;
        sd_next    = sd_reg;
        err_next   = err_reg;
        cmp_next   = cmp_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        wv_next    = wv_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        u_a        = '0;
        u_b        = '0;
        u_sub      = 1'b0;
        stat.ready = 1'b0;
        stat.done  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                stat.ready = 1'b1;
                if (start) begin
                    cmd_next   = rna_cmd_t'(op_in.command);
                    an_next    = ea_n;
                    ad_next    = ea_d;
                    bn_next    = eb_n;
                    bd_next    = eb_d;
                    wv_next    = e_w;
                    cmp_next   = 1'b0;
                    phase_next = '0;
                    case (rna_cmd_t'(op_in.command))
                        CMD_REDUCE: begin
                            n_next     = ea_n;
                            d_next     = ea_d;
                            err_next   = a_bad;
                            state_next = ST_RD_CHECK;
                        end
                        CMD_NEGATE: begin
                            err_next   = a_bad;
                            state_next = ST_NEGATE;
                        end
                        CMD_RECIP: begin
                            if (ea_n == '0) begin
                                n_next   = ea_n;
                                d_next   = ea_d;
                                err_next = 1'b1;
                            end else begin
                                n_next   = ea_d;
                                d_next   = ea_n;
                                err_next = a_bad;
                            end
                            state_next = ST_FIN;
                        end
                        CMD_MULTIPLY: begin
                            err_next   = a_bad | b_bad;
                            state_next = ST_MLOAD;
                        end
                        CMD_ADD_INT: begin
                            err_next   = a_bad;
                            state_next = ST_MLOAD;
                        end
                        CMD_FROM_INT: begin
                            n_next     = e_w;
                            d_next     = PW'(1);
                            err_next   = 1'b0;
                            state_next = ST_FIN;
                        end
                        CMD_EQUAL: begin
                            n_next     = ea_n;
                            d_next     = ea_d;
                            err_next   = a_bad | b_bad;
                            state_next = ST_RD_CHECK;
                        end
                        CMD_LESS: begin
                            err_next   = a_bad | b_bad;
                            state_next = ST_NORM;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_NEGATE: begin
                u_sub      = 1'b1;
                u_b        = an_reg;
                n_next     = u_sum;
                d_next     = ad_reg;
                state_next = ST_FIN;
            end

            // Move the sign of each denominator onto its numerator, one word per cycle.
            ST_NORM: begin
                u_sub = 1'b1;
                case (phase_reg)
                    2'd0: begin
                        u_b = an_reg;
                        if (neg_cond) an_next = u_sum;
                    end
                    2'd1: begin
                        u_b = ad_reg;
                        if (neg_cond) ad_next = u_sum;
                    end
                    2'd2: begin
                        u_b = bn_reg;
                        if (neg_cond) bn_next = u_sum;
                    end
                    default: begin
                        u_b = bd_reg;
                        if (neg_cond) bd_next = u_sum;
                    end
                endcase
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3) begin
                    state_next = ST_MLOAD;
                end
            end

            ST_MLOAD: begin
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
                case (cmd_reg)
                    CMD_MULTIPLY: begin
                        mc_next = phase_reg[0] ? ad_reg : an_reg;
                        mp_next = phase_reg[0] ? bd_reg : bn_reg;
                    end
                    CMD_ADD_INT: begin
                        mc_next = wv_reg;
                        mp_next = ad_reg;
                    end
                    CMD_LESS: begin
                        mc_next = phase_reg[0] ? bn_reg : an_reg;
                        mp_next = phase_reg[0] ? ad_reg : bd_reg;
                    end
                    default: begin
                        mc_next = an_reg;
                        mp_next = bn_reg;
                    end
                endcase
            end

            // One multiplier bit a cycle; the top bit carries negative weight.
            ST_MUL: begin
                u_a      = acc_reg;
                u_b      = mc_reg;
                u_sub    = (cnt_reg == CW'(W));
                acc_next = prod;
                mc_next  = mc_reg <<< 1;
                mp_next  = mp_reg >>> 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W)) begin
                    cnt_next = '0;
                    case (cmd_reg)
                        CMD_MULTIPLY: begin
                            if (phase_reg[0]) begin
                                d_next     = prod;
                                phase_next = '0;
                                state_next = ST_RD_CHECK;
                            end else begin
                                n_next     = prod;
                                phase_next = 2'd1;
                                state_next = ST_MLOAD;
                            end
                        end
                        CMD_ADD_INT: begin
                            state_next = ST_ADDN;
                        end
                        CMD_LESS: begin
                            if (phase_reg[0]) begin
                                d_next     = prod;
                                state_next = ST_CMP;
                            end else begin
                                n_next     = prod;
                                phase_next = 2'd1;
                                state_next = ST_MLOAD;
                            end
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_ADDN: begin
                u_a        = acc_reg;
                u_b        = an_reg;
                n_next     = u_sum;
                d_next     = ad_reg;
                state_next = ST_RD_CHECK;
            end

            ST_CMP: begin
                u_a        = n_reg;
                u_b        = d_reg;
                u_sub      = 1'b1;
                cmp_next   = u_sum[PW-1];
                n_next     = '0;
                d_next     = '0;
                state_next = ST_FIN;
            end

            // A zero part settles the reduction without a GCD.
            ST_RD_CHECK: begin
                if (n_reg == '0 && d_reg == '0) begin
                    state_next = ST_RD_END;
                end else if (n_reg == '0) begin
                    d_next     = PW'(1);
                    state_next = ST_RD_END;
                end else if (d_reg == '0) begin
                    n_next     = n_reg[PW-1] ? '1 : PW'(1);
                    state_next = ST_RD_END;
                end else begin
                    sn_next    = n_reg[PW-1];
                    sd_next    = d_reg[PW-1];
                    state_next = ST_RD_ABSN;
                end
            end

            ST_RD_ABSN: begin
                u_sub = 1'b1;
                u_b   = n_reg;
                if (sn_reg) n_next = u_sum;
                state_next = ST_RD_ABSD;
            end

            ST_RD_ABSD: begin
                u_sub = 1'b1;
                u_b   = d_reg;
                if (sd_reg) d_next = u_sum;
                state_next = ST_RD_TWOS;
            end

            // Common factors of two come off both magnitudes by shifting.
            ST_RD_TWOS: begin
                if (!n_reg[0] && !d_reg[0]) begin
                    n_next = n_reg >>> 1;
                    d_next = d_reg >>> 1;
                end else begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    state_next = ST_RD_GCD;
                end
            end

            ST_RD_GCD: begin
                u_a   = u_reg;
                u_b   = v_reg;
                u_sub = 1'b1;
                if (!u_reg[0]) begin
                    u_next = u_reg >>> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >>> 1;
                end else if (u_flags.zero) begin
                    u_next     = '0;
                    cnt_next   = '0;
                    dsel_next  = 1'b0;
                    state_next = ST_RD_DIV;
                end else if (!u_flags.carry) begin
                    u_next = v_reg;
                    v_next = u_reg;
                end else begin
                    u_next = u_sum;
                end
            end

            // Restoring division of each magnitude by the odd GCD held in v_reg.
            ST_RD_DIV: begin
                u_a      = div_rs;
                u_b      = v_reg;
                u_sub    = 1'b1;
                u_next   = u_flags.carry ? u_sum : div_rs;
                cnt_next = cnt_reg + CW'(1);
                if (dsel_reg) begin
                    d_next = {div_q[PW-2:0], u_flags.carry};
                end else begin
                    n_next = {div_q[PW-2:0], u_flags.carry};
                end
                if (cnt_reg == CW'(PW - 1)) begin
                    cnt_next = '0;
                    u_next   = '0;
                    if (dsel_reg) begin
                        state_next = ST_RD_SIGN;
                    end else begin
                        dsel_next = 1'b1;
                    end
                end
            end

            ST_RD_SIGN: begin
                u_sub = 1'b1;
                u_b   = n_reg;
                if (sn_reg ^ sd_reg) n_next = u_sum;
                state_next = ST_RD_END;
            end

            ST_RD_END: begin
                if (cmd_reg == CMD_EQUAL && phase_reg == 2'd0) begin
                    an_next    = n_reg;
                    ad_next    = d_reg;
                    n_next     = bn_reg;
                    d_next     = bd_reg;
                    phase_next = 2'd1;
                    state_next = ST_RD_CHECK;
                end else if (cmd_reg == CMD_EQUAL) begin
                    cmp_next   = (n_reg == an_reg) && (d_reg == ad_reg);
                    n_next     = '0;
                    d_next     = '0;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                stat.done = 1'b1;
                if (take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.res_num      = RES_WIDTH'(n_reg);
    assign result.res_den      = RES_WIDTH'(d_reg);
    assign result.compare_true = cmp_reg;
    assign result.error        = err_reg;

    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD_GCD |-> (u_reg != '0) && (v_reg != '0))
        else $error("GCD operand reached zero");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD_DIV |-> (v_reg != '0) && (u_reg < v_reg))
        else $error("division remainder not below divisor");

    a_cmp_fraction: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && (cmd_reg == CMD_EQUAL || cmd_reg == CMD_LESS)
        |-> (n_reg == '0) && (d_reg == '0))
        else $error("comparison result carries a nonzero fraction");

    a_cmp_only: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && cmd_reg != CMD_EQUAL && cmd_reg != CMD_LESS |-> !cmp_reg)
        else $error("compare flag set on an arithmetic command");

endmodule

`default_nettype wire

// ===== hw/rtl/rational_number_alu.sv =====
// Rational-number ALU. Reciprocal and from-integer go straight to the result; negate is
// one adder pass; less-than moves denominator signs, cross-multiplies and compares. A
// reduction settles without a GCD when a part is zero, else its time depends on the data;
// multiply and add-integer run shift-add multiplies before one; equal chains two reductions.
// The engine works on one request at a time on its single shared adder.
// Reset (aresetn low, synchronous) empties the block and clears valids.
`default_nettype none

module rational_number_alu #(
    parameter int unsigned OPERAND_WIDTH = rna_pkg::OPERAND_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rna_pkg::rna_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output rna_pkg::rna_out_t m_payload
);
    import rna_pkg::*;

    // The engine takes a request only from its idle state, so s_ready follows the
    // engine alone. A finished result moves into the output register below, which
    // lets the next request start while the previous result waits for its transfer.
    logic          start;
    logic          take;
    rna_out_t      eng_result;
    rna_eng_stat_t eng_stat;

    logic     m_valid_reg, m_valid_next;
    rna_out_t m_payload_reg, m_payload_next;

    assign s_ready = eng_stat.ready;
    assign start   = s_valid && eng_stat.ready;

    // The engine hands over its result once the output register is free or is
    // being emptied by a transfer in the same cycle.
    assign take = eng_stat.done && (!m_valid_reg || m_ready);

    rna_engine #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .take    (take),
        .op_in   (s_payload),
        .result  (eng_result),
        .stat    (eng_stat)
    );

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (take) begin
            m_valid_next   = 1'b1;
            m_payload_next = eng_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The payload register needs no reset; it is only read while m_valid is high.
    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Accepting a request leaves the engine busy, with s_ready low, in the cycle after its transfer.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("engine ready right after accepting a request");

endmodule

`default_nettype wire
